FILE: hw/rtl/crt_pkg.sv
// Shared types, field positions and codes for the chunk residency table.
package crt_pkg;

   // Stream payload widths (data widths padded to whole bytes)
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   // Register port widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_BIT = 2;

   // Field widths
   localparam int COORD_W  = 16;
   localparam int UCOORD_W = 15;
   localparam int RADIUS_W = 15;
   localparam int SLOT_W   = 6;
   localparam int CNT_W    = 7;
   localparam int WIN_W    = 18;

   // Request tdata field positions
   localparam int REQ_X_LSB     = 0;
   localparam int REQ_Z_LSB     = 16;
   localparam int REQ_FORCE_BIT = 32;
   localparam int REQ_ALL_BIT   = 33;
   localparam int REQ_CX_LSB    = 34;
   localparam int REQ_CZ_LSB    = 50;
   localparam int REQ_RAD_LSB   = 66;

   // Reset value of both world limits
   localparam logic [UCOORD_W-1:0] LIMIT_RESET = 15'd16;

   typedef enum logic [2:0] {
      OP_ACTIVATE = 3'd0,
      OP_MARK     = 3'd1,
      OP_EVICT    = 3'd2,
      OP_TAKE     = 3'd3,
      OP_RENDER   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_FOUND = 3'd0,
      ST_NEW   = 3'd1,
      ST_FULL  = 3'd2,
      ST_OOB   = 3'd3,
      ST_NONE  = 3'd4
   } status_type;

   typedef enum logic {
      CSR_XLIM = 1'b0,
      CSR_ZLIM = 1'b1
   } csr_idx_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic advance;
      logic push_hold;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic no_scan;
      logic last_step;
      logic take_hit;
      logic hold_vld;
      logic rsp_free;
   } stat_type;

   // One result item
   typedef struct packed {
      status_type             status;
      logic [SLOT_W-1:0]      slot;
      logic                   render;
      logic [UCOORD_W-1:0]    out_x;
      logic [UCOORD_W-1:0]    out_z;
      logic [CNT_W-1:0]       removed;
      logic                   last;
   } rsp_type;

endpackage

FILE: hw/rtl/crt_csr.sv
// Register port holding the world x and z limits.
module crt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [crt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [crt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [crt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [crt_pkg::UCOORD_W-1:0]    x_limit,
   output logic [crt_pkg::UCOORD_W-1:0]    z_limit
);
   import crt_pkg::*;

   logic [UCOORD_W-1:0] xlim_ff;
   logic [UCOORD_W-1:0] zlim_ff;
   logic                wr_en;
   csr_idx_type         idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_idx_type'(csr_paddr[CSR_IDX_BIT]);

   // Write the addressed limit
   always_ff @(posedge clock) begin
      if (reset) begin
         xlim_ff <= LIMIT_RESET;
         zlim_ff <= LIMIT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            CSR_XLIM: xlim_ff <= csr_pwdata[UCOORD_W-1:0];
            CSR_ZLIM: zlim_ff <= csr_pwdata[UCOORD_W-1:0];
            default:  ;
         endcase
      end
   end

   // Read back the addressed limit
   always_comb begin
      unique case (idx)
         CSR_XLIM: csr_prdata = CSR_DATA_W'(xlim_ff);
         CSR_ZLIM: csr_prdata = CSR_DATA_W'(zlim_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign x_limit = xlim_ff;
   assign z_limit = zlim_ff;

endmodule

FILE: hw/rtl/crt_ctrl.sv
// Controller state machine: accept, slot scan sequencing, final result.
module crt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  crt_pkg::stat_type  stat,
   output crt_pkg::cmd_type   cmd
);
   import crt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      stall;

   // Hold the scan while a take result cannot be handed on
   assign stall = stat.take_hit & stat.hold_vld & ~stat.rsp_free;

   always_comb begin
      cmd           = '0;
      cmd.start     = (state_ff == S_IDLE) & req_tvalid & ready_ff;
      cmd.advance   = (state_ff == S_SCAN) & ~stat.no_scan & ~stall;
      cmd.push_hold = cmd.advance & stat.take_hit & stat.hold_vld;
      cmd.finish    = (state_ff == S_FINISH) & stat.rsp_free;
   end

   // Sequence one item at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  state_ff <= S_SCAN;
                  ready_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (stat.no_scan || (cmd.advance && stat.last_step)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.finish) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = ready_ff;

endmodule

FILE: hw/rtl/crt_dpath.sv
// Datapath: slot marks, coordinate memory, scan stage and result register.
module crt_dpath #(
   parameter int SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  crt_pkg::cmd_type                cmd,
   output crt_pkg::stat_type               stat,
   input  logic [crt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [crt_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic [crt_pkg::UCOORD_W-1:0]    x_limit,
   input  logic [crt_pkg::UCOORD_W-1:0]    z_limit,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [crt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [crt_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);
   import crt_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW = IW + 1;
   localparam logic [AW-1:0] ADDR_END = AW'(SLOTS);
   localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

   // Item registers
   logic [2:0]                op_ff;
   logic [COORD_W-1:0]        x_ff;
   logic [COORD_W-1:0]        z_ff;
   logic                      force_ff;
   logic                      all_ff;
   logic signed [WIN_W-1:0]   cxp_ff, cxm_ff, czp_ff, czm_ff;
   logic                      oob_ff;

   // Slot marks and coordinate memory
   logic [SLOTS-1:0]          active_ff, active_in;
   logic [SLOTS-1:0]          pend_ff, pend_in;
   logic [UCOORD_W-1:0]       mem_x [SLOTS];
   logic [UCOORD_W-1:0]       mem_z [SLOTS];

   // Scan stage
   logic [AW-1:0]             addr_ff;
   logic                      s_vld_ff;
   logic [IW-1:0]             s_idx_ff;
   logic [UCOORD_W-1:0]       s_x_ff, s_z_ff;

   // Search results
   logic                      match_vld_ff, free_vld_ff;
   logic [IW-1:0]             match_idx_ff, free_idx_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      hold_vld_ff;
   rsp_type                   hold_ff;
   logic                      rsp_vld_ff;
   rsp_type                   rsp_ff;

   // Request fields
   logic [COORD_W-1:0]        req_x, req_z, req_cx, req_cz;
   logic [RADIUS_W-1:0]       req_rad;
   logic signed [WIN_W-1:0]   cx_w, cz_w, rad_w;
   logic                      oob_in;

   // Stage decode
   logic                      mem_re, mem_we, step;
   logic                      s_act, s_pnd, s_match, s_free, s_outside, s_evict;
   logic                      take_hit, s_inb;
   logic signed [WIN_W-1:0]   s_sx, s_sz;
   logic                      is_find, op_known;
   logic                      fin_find, fin_draw, fin_alloc, fin_mark;
   rsp_type                   take_res, fin;

   // Unpack request and build window edges
   assign req_x   = req_tdata[REQ_X_LSB +: COORD_W];
   assign req_z   = req_tdata[REQ_Z_LSB +: COORD_W];
   assign req_cx  = req_tdata[REQ_CX_LSB +: COORD_W];
   assign req_cz  = req_tdata[REQ_CZ_LSB +: COORD_W];
   assign req_rad = req_tdata[REQ_RAD_LSB +: RADIUS_W];
   assign cx_w    = {{(WIN_W-COORD_W){req_cx[COORD_W-1]}}, req_cx};
   assign cz_w    = {{(WIN_W-COORD_W){req_cz[COORD_W-1]}}, req_cz};
   assign rad_w   = {{(WIN_W-RADIUS_W){1'b0}}, req_rad};
   assign oob_in  = req_x[COORD_W-1] | req_z[COORD_W-1] |
                    (req_x[UCOORD_W-1:0] >= x_limit) |
                    (req_z[UCOORD_W-1:0] >= z_limit);

   // Latch the item
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_tuser;
         x_ff     <= req_x;
         z_ff     <= req_z;
         force_ff <= req_tdata[REQ_FORCE_BIT];
         all_ff   <= req_tdata[REQ_ALL_BIT];
         cxp_ff   <= cx_w + rad_w;
         cxm_ff   <= cx_w - rad_w;
         czp_ff   <= cz_w + rad_w;
         czm_ff   <= cz_w - rad_w;
         oob_ff   <= oob_in;
      end
   end

   assign is_find  = (op_ff == OP_ACTIVATE) | (op_ff == OP_RENDER);
   assign op_known = is_find | (op_ff == OP_MARK) | (op_ff == OP_EVICT) |
                     (op_ff == OP_TAKE);

   // Decode the slot at the scan stage
   assign step      = cmd.advance & s_vld_ff;
   assign s_act     = active_ff[s_idx_ff];
   assign s_pnd     = pend_ff[s_idx_ff];
   assign s_match   = s_vld_ff & s_act & ~x_ff[COORD_W-1] & ~z_ff[COORD_W-1] &
                      (s_x_ff == x_ff[UCOORD_W-1:0]) & (s_z_ff == z_ff[UCOORD_W-1:0]);
   assign s_free    = s_vld_ff & ~s_act;
   assign s_sx      = {{(WIN_W-UCOORD_W){1'b0}}, s_x_ff};
   assign s_sz      = {{(WIN_W-UCOORD_W){1'b0}}, s_z_ff};
   assign s_outside = (s_sx > cxp_ff) | (s_sx < cxm_ff) | (s_sz > czp_ff) | (s_sz < czm_ff);
   assign s_evict   = s_vld_ff & (op_ff == OP_EVICT) & s_act & s_outside;
   assign take_hit  = s_vld_ff & (op_ff == OP_TAKE) & s_act & s_pnd;
   assign s_inb     = (s_x_ff < x_limit) & (s_z_ff < z_limit);

   // Result of a take hit
   always_comb begin
      take_res         = '0;
      take_res.status  = s_inb ? ST_FOUND : ST_OOB;
      take_res.slot    = SLOT_W'(s_idx_ff);
      take_res.render  = s_inb;
      take_res.out_x   = s_x_ff;
      take_res.out_z   = s_z_ff;
   end

   // Final decisions at the end of the item
   assign fin_find  = cmd.finish & ~hold_vld_ff & is_find & ~oob_ff;
   assign fin_draw  = fin_find & match_vld_ff & (op_ff == OP_RENDER) &
                      (pend_ff[match_idx_ff] | force_ff);
   assign fin_alloc = fin_find & ~match_vld_ff & free_vld_ff;
   assign fin_mark  = cmd.finish & ~hold_vld_ff & (op_ff == OP_MARK) & match_vld_ff;
   assign mem_we    = fin_alloc;
   assign mem_re    = cmd.advance & (addr_ff < ADDR_END);

   // Final result item
   always_comb begin
      fin        = '0;
      fin.status = ST_NONE;
      if (hold_vld_ff) begin
         fin = hold_ff;
      end else begin
         unique case (op_ff)
            OP_ACTIVATE, OP_RENDER: begin
               if (oob_ff) begin
                  fin.status = ST_OOB;
               end else if (match_vld_ff) begin
                  fin.status = ST_FOUND;
                  fin.slot   = SLOT_W'(match_idx_ff);
                  fin.out_x  = x_ff[UCOORD_W-1:0];
                  fin.out_z  = z_ff[UCOORD_W-1:0];
                  fin.render = (op_ff == OP_RENDER) & (pend_ff[match_idx_ff] | force_ff);
               end else if (free_vld_ff) begin
                  fin.status = ST_NEW;
                  fin.slot   = SLOT_W'(free_idx_ff);
                  fin.out_x  = x_ff[UCOORD_W-1:0];
                  fin.out_z  = z_ff[UCOORD_W-1:0];
                  fin.render = (op_ff == OP_RENDER);
               end else begin
                  fin.status = ST_FULL;
               end
            end
            OP_MARK: begin
               if (match_vld_ff) begin
                  fin.status = ST_FOUND;
                  fin.slot   = SLOT_W'(match_idx_ff);
                  fin.out_x  = x_ff[UCOORD_W-1:0];
                  fin.out_z  = z_ff[UCOORD_W-1:0];
               end
            end
            OP_EVICT: fin.removed = count_ff;
            default:  ;
         endcase
      end
      fin.last = 1'b1;
   end

   // Next slot marks
   always_comb begin
      active_in = active_ff;
      pend_in   = pend_ff;
      if (step && s_evict) begin
         active_in[s_idx_ff] = 1'b0;
         pend_in[s_idx_ff]   = 1'b0;
      end
      if (step && take_hit && s_inb) begin
         pend_in[s_idx_ff] = 1'b0;
      end
      if (fin_alloc) begin
         active_in[free_idx_ff] = 1'b1;
         pend_in[free_idx_ff]   = (op_ff == OP_ACTIVATE);
      end
      if (fin_draw) begin
         pend_in[match_idx_ff] = 1'b0;
      end
      if (fin_mark) begin
         pend_in[match_idx_ff] = 1'b1;
      end
   end

   // Coordinate memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[free_idx_ff] <= x_ff[UCOORD_W-1:0];
         mem_z[free_idx_ff] <= z_ff[UCOORD_W-1:0];
      end
      if (mem_re) begin
         s_x_ff <= mem_x[addr_ff[IW-1:0]];
         s_z_ff <= mem_z[addr_ff[IW-1:0]];
      end
   end

   // Advance the scan and collect search results
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         pend_ff      <= '0;
         addr_ff      <= '0;
         s_vld_ff     <= 1'b0;
         match_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         count_ff     <= '0;
         hold_vld_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         if (cmd.start) begin
            addr_ff      <= '0;
            s_vld_ff     <= 1'b0;
            match_vld_ff <= 1'b0;
            free_vld_ff  <= 1'b0;
            count_ff     <= '0;
            hold_vld_ff  <= 1'b0;
         end else begin
            if (cmd.advance) begin
               s_vld_ff <= mem_re;
               if (mem_re) begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            if (step && s_match && !match_vld_ff) begin
               match_vld_ff <= 1'b1;
            end
            if (step && s_free && !free_vld_ff) begin
               free_vld_ff <= 1'b1;
            end
            if (step && s_evict) begin
               count_ff <= count_ff + 1'b1;
            end
            if (cmd.finish) begin
               hold_vld_ff <= 1'b0;
            end else if (step && take_hit) begin
               hold_vld_ff <= 1'b1;
            end
         end
      end
   end

   // Slot indexes and held take result
   always_ff @(posedge clock) begin
      if (mem_re) begin
         s_idx_ff <= addr_ff[IW-1:0];
      end
      if (step && s_match && !match_vld_ff) begin
         match_idx_ff <= s_idx_ff;
      end
      if (step && s_free && !free_vld_ff) begin
         free_idx_ff <= s_idx_ff;
      end
      if (step && take_hit) begin
         hold_ff <= take_res;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.push_hold || cmd.finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_hold) begin
         rsp_ff <= hold_ff;
      end else if (cmd.finish) begin
         rsp_ff <= fin;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.removed, rsp_ff.out_z, rsp_ff.out_x,
                                    rsp_ff.render, rsp_ff.slot});

   // Status to the controller
   assign stat.no_scan   = (is_find & oob_ff) | ~op_known;
   assign stat.last_step = s_vld_ff & ((s_idx_ff == IDX_LAST) | (take_hit & ~all_ff));
   assign stat.take_hit  = take_hit;
   assign stat.hold_vld  = hold_vld_ff;
   assign stat.rsp_free  = ~rsp_vld_ff | rsp_tready;

`ifndef SYNTHESIS
   a_pend_needs_active: assert property (@(posedge clock) disable iff (reset)
      (pend_ff & ~active_ff) == '0)
      else $error("pending mark on an inactive slot");

   a_push_hold_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.push_hold |-> (hold_vld_ff && stat.rsp_free))
      else $error("held result pushed while empty or output busy");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.rsp_free)
      else $error("final result overwrote an unread result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("eviction count beyond table size");

   a_hold_take_only: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> (op_ff == OP_TAKE))
      else $error("held result outside take pending");
`endif

endmodule

FILE: hw/rtl/chunk_residency_table.sv
// Top level of the chunk residency table: register port, controller and datapath.
//
//  port group   dir  handshake          payload
//  req_*        in   tvalid/tready      tuser opcode, tdata coordinates and options
//  rsp_*        out  tvalid/tready      tuser status, tdata slot result, tlast
//  csr_*        in   psel/penable       x limit at 0x0, z limit at 0x4
//
//  An item runs through accept, a slot scan through the registered read of the slot
//  coordinate memory, and the final result.
//  Out-of-bounds activate or render requests and unused opcodes do not scan the slots.
//  Take pending with take_all also waits whenever rsp_tready holds a result back.
//  On reset all slot marks clear and both limits return to 16.
//  One item is in flight at a time; a new item is taken while a result waits.
module chunk_residency_table #(
   parameter int SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] chunk_x, [31:16] chunk_z, [32] force_req, [33] take_all,
   // [49:34] center_x, [65:50] center_z, [80:66] radius, [87:81] zero
   input  logic [crt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] opcode
   input  logic [crt_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] slot, [6] render_needed, [21:7] out_x, [36:22] out_z,
   // [43:37] removed_count, [47:44] zero
   output logic [crt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] status
   output logic [crt_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [crt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [crt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [crt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import crt_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   logic [UCOORD_W-1:0]  x_limit;
   logic [UCOORD_W-1:0]  z_limit;

   crt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .x_limit     (x_limit),
      .z_limit     (z_limit)
   );

   crt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   crt_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .x_limit    (x_limit),
      .z_limit    (z_limit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
